// ----- hw/rtl/unique_value_set_store_defines.svh -----
// Assertion macros for the unique value set store checker.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef UNIQUE_VALUE_SET_STORE_DEFINES_SVH
`define UNIQUE_VALUE_SET_STORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define UVSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("unique_value_set_store check failed");

// Next-cycle implication, sampled on aclk and disabled during reset.
`define UVSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("unique_value_set_store check failed");

`endif

// ----- hw/rtl/uvss_pkg.sv -----
// Shared types and constants for the unique value set store.
// Depends on nothing.
package uvss_pkg;

    localparam int COUNT_WIDTH = 7;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_LIST   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_ADDED      = 3'd0,
        STATUS_REMOVED    = 3'd1,
        STATUS_FULL       = 3'd2,
        STATUS_DUPLICATE  = 3'd3,
        STATUS_EMPTY      = 3'd4,
        STATUS_NOT_FOUND  = 3'd5,
        STATUS_ENTRY      = 3'd6,
        STATUS_LIST_EMPTY = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [COUNT_WIDTH-1:0] count;
    } cell_ctrl_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        status_t                status;
        logic signed [31:0]     entry_value;
        logic [COUNT_WIDTH-1:0] entry_count;
        logic                   last;
    } out_item_t;

endpackage

// ----- hw/rtl/uvss_cell.sv -----
// One storage cell of the entry chain: holds a word, matches it against the key,
// and loads from the key, its upper neighbor or the head cell. Depends on uvss_pkg.
module uvss_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX       = 0
) (
    input  logic                   aclk,
    input  uvss_pkg::cell_ctrl_t   ctrl,
    input  logic [VALUE_WIDTH-1:0] key,
    input  logic [VALUE_WIDTH-1:0] next_value,
    input  logic [VALUE_WIDTH-1:0] head_value,
    input  logic                   seen_in,
    output logic                   seen_out,
    output logic [VALUE_WIDTH-1:0] value
);

    localparam logic [uvss_pkg::COUNT_WIDTH-1:0] MyIndex = uvss_pkg::COUNT_WIDTH'(INDEX);
    localparam logic [uvss_pkg::COUNT_WIDTH-1:0] NextIndex =
        uvss_pkg::COUNT_WIDTH'(INDEX + 1);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   occupied;
    logic                   match;

    assign occupied = MyIndex < ctrl.count;
    assign match    = occupied && (value_reg == key);
    assign seen_out = seen_in || match;
    assign value    = value_reg;

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            uvss_pkg::CELL_APPEND: begin
                if (MyIndex == ctrl.count) begin
                    value_reg <= key;
                end
            end
            uvss_pkg::CELL_DELETE: begin
                if (seen_out) begin
                    value_reg <= next_value;
                end
            end
            uvss_pkg::CELL_ROTATE: begin
                if (NextIndex == ctrl.count) begin
                    value_reg <= head_value;
                end else if (NextIndex < ctrl.count) begin
                    value_reg <= next_value;
                end
            end
            default: begin
                value_reg <= value_reg;
            end
        endcase
    end

endmodule

// ----- hw/rtl/unique_value_set_store.sv -----
// Unique value set store: an ordered store of up to CAPACITY words kept in a chain of
// cells, one word per cell. For append, insert and delete the item is accepted into the
// key register; then, once the output register is free, every cell compares its word
// with the key at once and the chain loads or shifts down, producing one result item.
// For a list the chain rotates by one cell per cycle while the output register is free
// and the head cell's word is sent out, so after a full list the order is as before.
// The input is ready again once the result is registered, while it still waits to be
// taken. There is no clearing pass after reset; the store begins empty. Depends on
// uvss_pkg and uvss_cell.
module unique_value_set_store #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  uvss_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output uvss_pkg::out_item_t m_item
);

    localparam int CW = uvss_pkg::COUNT_WIDTH;
    localparam logic [CW-1:0] Capacity = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LIST
    } state_t;

    state_t                 state_reg;
    uvss_pkg::mode_t        mode_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          list_idx_reg;
    logic                   m_valid_reg;
    uvss_pkg::out_item_t    m_item_reg;

    uvss_pkg::cell_ctrl_t   ctrl;
    logic                   out_free;
    logic                   full;
    logic                   found;
    logic                   list_last;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] next_value [CAPACITY];
    logic                   seen       [CAPACITY+1];

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign full      = count_reg >= Capacity;
    assign found     = seen[CAPACITY];
    assign list_last = (CW'(list_idx_reg + CW'(1)) == count_reg);
    assign seen[0]   = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == CAPACITY - 1) begin : g_tail
            assign next_value[i] = cell_value[i];
        end else begin : g_body
            assign next_value[i] = cell_value[i+1];
        end

        uvss_cell #(
            .VALUE_WIDTH(VALUE_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .key       (key_reg),
            .next_value(next_value[i]),
            .head_value(cell_value[0]),
            .seen_in   (seen[i]),
            .seen_out  (seen[i+1]),
            .value     (cell_value[i])
        );
    end

    always_comb begin
        ctrl.op    = uvss_pkg::CELL_HOLD;
        ctrl.count = count_reg;
        if (state_reg == ST_EXEC && out_free) begin
            case (mode_reg)
                uvss_pkg::MODE_APPEND: begin
                    if (!full) begin
                        ctrl.op = uvss_pkg::CELL_APPEND;
                    end
                end
                uvss_pkg::MODE_INSERT: begin
                    if (!full && !found) begin
                        ctrl.op = uvss_pkg::CELL_APPEND;
                    end
                end
                uvss_pkg::MODE_DELETE: begin
                    if (count_reg != '0) begin
                        ctrl.op = uvss_pkg::CELL_DELETE;
                    end
                end
                default: begin
                    ctrl.op = uvss_pkg::CELL_HOLD;
                end
            endcase
        end else if (state_reg == ST_LIST && out_free) begin
            ctrl.op = uvss_pkg::CELL_ROTATE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (s_valid) begin
                        mode_reg  <= s_item.mode;
                        key_reg   <= VALUE_WIDTH'({32'd0, s_item.value});
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        m_item_reg.entry_value <= '0;
                        m_item_reg.last        <= 1'b1;
                        case (mode_reg)
                            uvss_pkg::MODE_APPEND, uvss_pkg::MODE_INSERT: begin
                                m_valid_reg <= 1'b1;
                                state_reg   <= ST_IDLE;
                                if (full) begin
                                    m_item_reg.entry_count <= count_reg;
                                    m_item_reg.status      <= uvss_pkg::STATUS_FULL;
                                end else if (mode_reg == uvss_pkg::MODE_INSERT && found) begin
                                    m_item_reg.entry_count <= count_reg;
                                    m_item_reg.status      <= uvss_pkg::STATUS_DUPLICATE;
                                end else begin
                                    count_reg              <= CW'(count_reg + CW'(1));
                                    m_item_reg.entry_count <= CW'(count_reg + CW'(1));
                                    m_item_reg.status      <= uvss_pkg::STATUS_ADDED;
                                end
                            end
                            uvss_pkg::MODE_DELETE: begin
                                m_valid_reg <= 1'b1;
                                state_reg   <= ST_IDLE;
                                if (count_reg == '0) begin
                                    m_item_reg.entry_count <= count_reg;
                                    m_item_reg.status      <= uvss_pkg::STATUS_EMPTY;
                                end else if (!found) begin
                                    m_item_reg.entry_count <= count_reg;
                                    m_item_reg.status      <= uvss_pkg::STATUS_NOT_FOUND;
                                end else begin
                                    count_reg              <= CW'(count_reg - CW'(1));
                                    m_item_reg.entry_count <= CW'(count_reg - CW'(1));
                                    m_item_reg.status      <= uvss_pkg::STATUS_REMOVED;
                                end
                            end
                            default: begin
                                m_item_reg.entry_count <= count_reg;
                                if (count_reg == '0) begin
                                    m_item_reg.status <= uvss_pkg::STATUS_LIST_EMPTY;
                                    m_valid_reg       <= 1'b1;
                                    state_reg         <= ST_IDLE;
                                end else begin
                                    m_valid_reg  <= 1'b0;
                                    list_idx_reg <= '0;
                                    state_reg    <= ST_LIST;
                                end
                            end
                        endcase
                    end
                end
                ST_LIST: begin
                    if (out_free) begin
                        m_item_reg.status      <= uvss_pkg::STATUS_ENTRY;
                        m_item_reg.entry_value <= signed'(32'(cell_value[0]));
                        m_item_reg.entry_count <= count_reg;
                        m_item_reg.last        <= list_last;
                        m_valid_reg            <= 1'b1;
                        list_idx_reg           <= CW'(list_idx_reg + CW'(1));
                        if (list_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/uvss_checker.sv -----
// Port-level checks for the unique value set store, bound to the top level.
// Depends on uvss_pkg and unique_value_set_store_defines.svh.
`include "unique_value_set_store_defines.svh"

module uvss_checker #(
    parameter int CAPACITY = 64
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input uvss_pkg::out_item_t m_item
);

    `UVSS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item))
    `UVSS_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)
    `UVSS_ASSERT_IMP(a_count_bound, m_valid,
        m_item.entry_count <= uvss_pkg::COUNT_WIDTH'(CAPACITY))
    `UVSS_ASSERT_IMP(a_value_zero, m_valid && m_item.status != uvss_pkg::STATUS_ENTRY,
        m_item.entry_value == '0)
    `UVSS_ASSERT_IMP(a_single_last, m_valid && m_item.status != uvss_pkg::STATUS_ENTRY,
        m_item.last)

endmodule

bind unique_value_set_store uvss_checker #(
    .CAPACITY(CAPACITY)
) u_uvss_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_item (m_item)
);

// ----- test/testbench.sv -----
// Self-checking testbench for unique_value_set_store: a clocked driver and monitor
// exercise append, insert, delete and list items against a shadow copy of the store.
// Depends on uvss_pkg and the unique_value_set_store RTL.
module testbench;
    import uvss_pkg::*;

    localparam int CAPACITY = 64;
    localparam int VALUE_WIDTH = 32;
    localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF >> (32 - VALUE_WIDTH);
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    logic aclk;
    logic aresetn;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;

    in_item_t command_queue[$];
    out_item_t awaited_responses[$];
    logic [31:0] shadow_words[$];
    logic signed [31:0] word_pool[16];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    unique_value_set_store #(
        .CAPACITY(CAPACITY),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic compute_set_response(input in_item_t cmd);
        logic [31:0] key;
        int hit;
        out_item_t resp;
        key = cmd.value & WORD_MASK;
        hit = -1;
        foreach (shadow_words[i]) begin
            if (hit < 0 && shadow_words[i] == key) hit = i;
        end
        resp = '0;
        resp.last = 1'b1;
        case (cmd.mode)
            MODE_APPEND, MODE_INSERT: begin
                if (shadow_words.size() >= CAPACITY) begin
                    resp.status = STATUS_FULL;
                end else if (cmd.mode == MODE_INSERT && hit >= 0) begin
                    resp.status = STATUS_DUPLICATE;
                end else begin
                    shadow_words.push_back(key);
                    resp.status = STATUS_ADDED;
                end
            end
            MODE_DELETE: begin
                if (shadow_words.size() == 0) begin
                    resp.status = STATUS_EMPTY;
                end else if (hit < 0) begin
                    resp.status = STATUS_NOT_FOUND;
                end else begin
                    shadow_words.delete(hit);
                    resp.status = STATUS_REMOVED;
                end
            end
            default: begin
                if (shadow_words.size() == 0) begin
                    resp.status = STATUS_LIST_EMPTY;
                end else begin
                    foreach (shadow_words[i]) begin
                        resp.status = STATUS_ENTRY;
                        resp.entry_value = shadow_words[i];
                        resp.entry_count = COUNT_WIDTH'(shadow_words.size());
                        resp.last = (i == shadow_words.size() - 1);
                        awaited_responses.push_back(resp);
                    end
                end
            end
        endcase
        if (!(cmd.mode == MODE_LIST && shadow_words.size() != 0)) begin
            resp.entry_count = COUNT_WIDTH'(shadow_words.size());
            awaited_responses.push_back(resp);
        end
    endtask

    // The driver presents the next pending item once the previous one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) compute_set_response(s_item);
            if (!s_valid || s_ready) begin
                if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item <= command_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_responses.size() == 0) begin
                    $error("unexpected result item: status %0d", m_item.status);
                    mismatch_count++;
                end else begin
                    want = awaited_responses.pop_front();
                    if (m_item.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_item.status);
                        mismatch_count++;
                    end
                    if (m_item.entry_value !== want.entry_value) begin
                        $error("entry_value expected %0d actual %0d",
                               want.entry_value, m_item.entry_value);
                        mismatch_count++;
                    end
                    if (m_item.entry_count !== want.entry_count) begin
                        $error("entry_count expected %0d actual %0d",
                               want.entry_count, m_item.entry_count);
                        mismatch_count++;
                    end
                    if (m_item.last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, m_item.last);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_command(input mode_t mode, input logic signed [31:0] value);
        in_item_t cmd;
        cmd.mode = mode;
        cmd.value = value;
        command_queue.push_back(cmd);
    endtask

    function automatic logic signed [31:0] pick_word();
        if ($urandom_range(99) < 65) return word_pool[$urandom_range(15)];
        return $urandom;
    endfunction

    // Percentages of append, insert and delete; the rest are list items.
    task automatic queue_mixed(input int count, input int pct_append, input int pct_insert,
                               input int pct_delete);
        int roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < pct_append) queue_command(MODE_APPEND, pick_word());
            else if (roll < pct_append + pct_insert) queue_command(MODE_INSERT, pick_word());
            else if (roll < pct_append + pct_insert + pct_delete)
                queue_command(MODE_DELETE, pick_word());
            else queue_command(MODE_LIST, $urandom);
        end
    endtask

    task automatic wait_for_drain();
        while (command_queue.size() != 0 || s_valid || awaited_responses.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        word_pool[0] = 32'sh8000_0000;
        word_pool[1] = 32'sh7FFF_FFFF;
        word_pool[2] = 32'sh0000_0000;
        word_pool[3] = -32'sd1;
        for (int i = 4; i < 16; i++) word_pool[i] = $urandom;

        send_idle_pct = 7;
        recv_idle_pct = 48;
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        queue_command(MODE_LIST, 32'sd0);
        queue_command(MODE_DELETE, 32'sd5);
        queue_command(MODE_INSERT, 32'sh8000_0000);
        queue_command(MODE_INSERT, 32'sh8000_0000);
        queue_command(MODE_APPEND, 32'sh7FFF_FFFF);
        queue_command(MODE_APPEND, 32'sh7FFF_FFFF);
        queue_command(MODE_INSERT, 32'sd0);
        queue_command(MODE_APPEND, -32'sd1);
        queue_command(MODE_DELETE, 32'sd12345);
        queue_command(MODE_DELETE, 32'sh7FFF_FFFF);
        queue_command(MODE_LIST, -32'sd1);
        queue_command(MODE_DELETE, 32'sh8000_0000);
        queue_command(MODE_INSERT, 32'sh7FFF_FFFF);
        queue_command(MODE_DELETE, 32'sh7FFF_FFFF);
        queue_command(MODE_DELETE, 32'sd0);
        queue_command(MODE_DELETE, -32'sd1);
        queue_command(MODE_LIST, 32'sh5A5A_5A5A);
        queue_command(MODE_APPEND, 32'sh5555_5555);
        queue_command(MODE_APPEND, 32'shAAAA_AAAA);
        queue_command(MODE_INSERT, 32'sh5555_5555);
        queue_command(MODE_LIST, 32'sh0F0F_0F0F);
        queue_mixed(40, 30, 30, 25);
        wait_for_drain();

        // Enough appends to fill the store from any level, then pushes against a full store.
        send_idle_pct = 48;
        recv_idle_pct = 7;
        repeat (CAPACITY + 2) queue_command(MODE_APPEND, pick_word());
        queue_command(MODE_INSERT, word_pool[0]);
        queue_command(MODE_INSERT, $urandom);
        queue_command(MODE_APPEND, $urandom);
        queue_command(MODE_LIST, $urandom);
        queue_mixed(30, 25, 25, 35);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_mixed(60, 10, 15, 60);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && awaited_responses.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
